// ----- rtl/bba_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Sizes of the free map, its row layout and the control words that pass
// between the scan sequencer and the free-map memory.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int CNT_W      = 7;
  localparam int BLK_W      = 6;
  localparam int ROW_W      = 8;
  localparam int BIT_IDX_W  = 3;
  localparam int NUM_ROWS   = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_IDX_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  localparam logic [CNT_W-1:0]     CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0]     CNT_MAX   = CNT_W'(MAX_BLOCKS);
  localparam logic [BIT_IDX_W-1:0] BIT_LAST  = BIT_IDX_W'(ROW_W - 1);
  localparam logic [ROW_IDX_W-1:0] ROW_LAST  = ROW_IDX_W'(NUM_ROWS - 1);

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic                 clear;
    logic                 rd_en;
    logic [ROW_IDX_W-1:0] rd_row;
    logic                 wr_en;
    logic [ROW_IDX_W-1:0] wr_row;
    logic [ROW_W-1:0]     wr_data;
  } map_req_t;

  typedef struct packed {
    logic             strobe;
    logic             status;
    logic             block_valid;
    logic [BLK_W-1:0] block_number;
    logic             is_first;
    logic             is_last;
    logic [CNT_W-1:0] free_left;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_blocks(input logic [CNT_W-1:0] value);
    return (value > CNT_MAX) ? CNT_MAX : value;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bitmap_block_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator: bitmap free-block allocator
// Claims the lowest-numbered free blocks for each request and reports one
// result word per claimed block, or one word for a rejected or empty request.
// ----------------------------------------------------------------------------
//  channel   handshake                     word
//  request   start / busy                  request_length_i
//  result    result_strobe_o (no stall)    status, block, first/last, free_left
//  config    cfg_valid_i / cfg_ready_o     cfg_data_i (num_blocks)
//
// A rejected or zero-length request is answered in the cycle after it is
// taken, and busy stays low. An allocation scans the free map row by row,
// eight blocks to a row: a read state fetches the row from the memory, a
// load state takes it in and a bit state checks its blocks one at a time.
// Results appear at most one per cycle.
// After reset all 64 blocks are free; per-row valid flags make a reset or a
// config write take effect at once, with no clearing pass.
// The receiver cannot stall; config is taken only while busy is low.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [bba_pkg::CNT_W-1:0] request_length_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bba_pkg::CNT_W-1:0] cfg_data_i,
  output logic                      result_strobe_o,
  output logic                      status_o,
  output logic                      block_valid_o,
  output logic [bba_pkg::BLK_W-1:0] block_number_o,
  output logic                      is_first_o,
  output logic                      is_last_o,
  output logic [bba_pkg::CNT_W-1:0] free_left_o
);
  import bba_pkg::*;

  logic [CNT_W-1:0] num_blocks_q, num_blocks_d;
  logic [CNT_W-1:0] cfg_num;
  logic             cfg_we;
  logic             seq_busy;
  map_req_t         map_req;
  logic [ROW_W-1:0] map_data;
  result_t          result;

  assign cfg_ready_o  = !seq_busy;
  assign cfg_we       = cfg_valid_i && cfg_ready_o;
  assign cfg_num      = sat_blocks(cfg_data_i);
  assign num_blocks_d = cfg_we ? cfg_num : num_blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_blocks_q <= CNT_MAX;
    end else begin
      num_blocks_q <= num_blocks_d;
    end
  end

  bba_free_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_data_o (map_data)
  );

  bba_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .request_length_i (request_length_i),
    .cfg_we_i         (cfg_we),
    .cfg_num_i        (cfg_num),
    .num_blocks_i     (num_blocks_q),
    .map_data_i       (map_data),
    .map_req_o        (map_req),
    .busy_o           (seq_busy),
    .result_o         (result)
  );

  assign busy            = seq_busy;
  assign result_strobe_o = result.strobe;
  assign status_o        = result.status;
  assign block_valid_o   = result.block_valid;
  assign block_number_o  = result.block_number;
  assign is_first_o      = result.is_first;
  assign is_last_o       = result.is_last;
  assign free_left_o     = result.free_left;

  a_end_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_strobe_o && is_last_o)
    else $error("allocation ended without a final result word");

  a_start_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || (result_strobe_o && is_last_o))
    else $error("accepted request neither scanned nor answered");

  a_block_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && block_valid_o |-> CNT_W'(block_number_o) < num_blocks_q)
    else $error("claimed block outside the blocks in use");

  a_no_map_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_req.clear |-> !map_req.wr_en && !map_req.rd_en)
    else $error("free map cleared during a scan");

endmodule
`default_nettype wire

// ----- rtl/bba_free_map.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bba_free_map: free-map memory
// One bit per block, eight blocks to a row, one synchronous read and one
// write port. A row that has not been written since the last clear reads
// as all free.
// ----------------------------------------------------------------------------
module bba_free_map (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bba_pkg::map_req_t        req_i,
  output logic [bba_pkg::ROW_W-1:0] rd_data_o
);
  import bba_pkg::*;

  logic [ROW_W-1:0] mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] row_vld_q;
  logic [ROW_W-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_row] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.clear) begin
        row_vld_q <= '0;
      end else if (req_i.wr_en) begin
        row_vld_q[req_i.wr_row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_row];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '1;

endmodule
`default_nettype wire

// ----- rtl/bba_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bba_seq: allocation sequencer
// Checks each request against the free count, then reads the free map row
// by row, claims free blocks one per cycle within a row, writes rows back.
// ----------------------------------------------------------------------------
module bba_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bba_pkg::CNT_W-1:0] request_length_i,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::CNT_W-1:0] cfg_num_i,
  input  logic [bba_pkg::CNT_W-1:0] num_blocks_i,
  input  logic [bba_pkg::ROW_W-1:0] map_data_i,
  output bba_pkg::map_req_t         map_req_o,
  output logic                      busy_o,
  output bba_pkg::result_t          result_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_BITS = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     len_q, len_d;
  logic [CNT_W-1:0]     claimed_q, claimed_d;
  logic [CNT_W-1:0]     free_cnt_q, free_cnt_d;
  logic [ROW_IDX_W-1:0] row_q, row_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [ROW_W-1:0]     work_q, work_d;
  result_t              res_q, res_d;

  logic [CNT_W-1:0] blk_idx;
  logic             in_range;
  logic             hit;
  logic             claim_last;
  logic             done;

  assign blk_idx    = CNT_W'({row_q, bit_q});
  assign in_range   = blk_idx < num_blocks_i;
  assign hit        = in_range && work_q[bit_q];
  assign claim_last = hit && ((claimed_q + CNT_ONE) == len_q);
  assign done       = claim_last || !in_range || ((bit_q == BIT_LAST) && (row_q == ROW_LAST));

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    claimed_d  = claimed_q;
    free_cnt_d = free_cnt_q;
    row_d      = row_q;
    bit_d      = bit_q;
    work_d     = work_q;
    res_d      = res_q;
    res_d.strobe      = 1'b0;
    map_req_o         = '0;
    map_req_o.clear   = cfg_we_i;
    map_req_o.rd_row  = row_q;
    map_req_o.wr_row  = row_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          free_cnt_d = cfg_num_i;
        end
        if (start_i) begin
          len_d              = request_length_i;
          res_d.block_valid  = 1'b0;
          res_d.block_number = '0;
          res_d.is_first     = 1'b0;
          res_d.is_last      = 1'b1;
          res_d.free_left    = free_cnt_q;
          if (request_length_i > free_cnt_q) begin
            res_d.strobe = 1'b1;
            res_d.status = STATUS_REJECT;
          end else if (request_length_i == '0) begin
            res_d.strobe = 1'b1;
            res_d.status = STATUS_OK;
          end else begin
            claimed_d = '0;
            row_d     = '0;
            bit_d     = '0;
            state_d   = ST_READ;
          end
        end
      end
      ST_READ: begin
        map_req_o.rd_en = 1'b1;
        state_d         = ST_LOAD;
      end
      ST_LOAD: begin
        work_d  = map_data_i;
        state_d = ST_BITS;
      end
      ST_BITS: begin
        if (hit) begin
          work_d[bit_q]      = 1'b0;
          claimed_d          = claimed_q + CNT_ONE;
          free_cnt_d         = free_cnt_q - CNT_ONE;
          res_d.strobe       = 1'b1;
          res_d.status       = STATUS_OK;
          res_d.block_valid  = 1'b1;
          res_d.block_number = BLK_W'(blk_idx);
          res_d.is_first     = (claimed_q == '0);
          res_d.is_last      = claim_last;
          res_d.free_left    = free_cnt_q - CNT_ONE;
        end
        bit_d = bit_q + BIT_IDX_W'(1);
        if (done || (bit_q == BIT_LAST)) begin
          map_req_o.wr_en   = 1'b1;
          map_req_o.wr_data = work_d;
          row_d             = row_q + ROW_IDX_W'(1);
          state_d           = done ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      free_cnt_q <= CNT_MAX;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    claimed_q <= claimed_d;
    row_q     <= row_d;
    bit_q     <= bit_d;
    work_q    <= work_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign result_o = res_q;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bitmap block allocator
// Drives allocation requests and block-count writes, predicts every result
// word from a bit-level model of the free map and compares each word field by
// field as it leaves the block. A short directed opening covers the edges,
// then short random phases, each after a fresh block count, keep the map busy.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  class alloc_tracker;
    logic [CNT_W-1:0]      block_count;
    logic [MAX_BLOCKS-1:0] free_map;
    logic [CNT_W-1:0]      free_count;
    result_t               awaited_words[$];
    int                    mismatches;

    function new();
      mismatches = 0;
      set_block_count(CNT_MAX);
    endfunction

    function void set_block_count(logic [CNT_W-1:0] value);
      block_count = (value > CNT_MAX) ? CNT_MAX : value;
      free_map = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (i < block_count) free_map[i] = 1'b1;
      end
      free_count = block_count;
    endfunction

    function void note_request(logic [CNT_W-1:0] length);
      result_t w;
      int      claimed;
      w = '0;
      w.strobe = 1'b1;
      claimed = 0;
      if (length > free_count || length == 0) begin
        w.status = (length > free_count) ? STATUS_REJECT : STATUS_OK;
        w.is_last = 1'b1;
        w.free_left = free_count;
        awaited_words.push_back(w);
      end else begin
        for (int i = 0; i < MAX_BLOCKS && claimed < length; i++) begin
          if (i < block_count && free_map[i]) begin
            free_map[i] = 1'b0;
            free_count = free_count - CNT_ONE;
            claimed++;
            w.status = STATUS_OK;
            w.block_valid = 1'b1;
            w.block_number = BLK_W'(i);
            w.is_first = (claimed == 1);
            w.is_last = (claimed == length);
            w.free_left = free_count;
            awaited_words.push_back(w);
          end
        end
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_word(result_t got);
      result_t want;
      if (awaited_words.size() == 0) begin
        report($sformatf("unexpected word, block %0d", got.block_number));
        return;
      end
      want = awaited_words.pop_front();
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.block_valid != want.block_valid)
        report($sformatf("block_valid %0d, want %0d", got.block_valid, want.block_valid));
      if (got.block_number != want.block_number)
        report($sformatf("block_number %0d, want %0d", got.block_number, want.block_number));
      if (got.is_first != want.is_first)
        report($sformatf("is_first %0d, want %0d", got.is_first, want.is_first));
      if (got.is_last != want.is_last)
        report($sformatf("is_last %0d, want %0d", got.is_last, want.is_last));
      if (got.free_left != want.free_left)
        report($sformatf("free_left %0d, want %0d", got.free_left, want.free_left));
    endtask
  endclass

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             start            = 1'b0;
  logic             busy;
  logic [CNT_W-1:0] request_length_i = '0;
  logic             cfg_valid_i      = 1'b0;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i       = '0;
  logic             result_strobe_o;
  logic             status_o;
  logic             block_valid_o;
  logic [BLK_W-1:0] block_number_o;
  logic             is_first_o;
  logic             is_last_o;
  logic [CNT_W-1:0] free_left_o;

  alloc_tracker tracker;
  bit           steady;

  bitmap_block_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .request_length_i (request_length_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .result_strobe_o  (result_strobe_o),
    .status_o         (status_o),
    .block_valid_o    (block_valid_o),
    .block_number_o   (block_number_o),
    .is_first_o       (is_first_o),
    .is_last_o        (is_last_o),
    .free_left_o      (free_left_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      tracker.check_word({1'b1, status_o, block_valid_o, block_number_o,
                          is_first_o, is_last_o, free_left_o});
    end
  end

  task automatic send_request(input int length);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    request_length_i <= CNT_W'(length);
    do @(posedge clk_i); while (busy);
    tracker.note_request(CNT_W'(length));
  endtask

  task automatic set_blocks(input int value);
    start <= 1'b0;
    while (tracker.awaited_words.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CNT_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_block_count(CNT_W'(value));
  endtask

  function automatic int pick_length();
    int roll;
    int room;
    roll = $urandom_range(0, 99);
    room = tracker.free_count;
    if (roll < 8) return 0;
    if (roll < 12 || (roll < 27 && room >= MAX_BLOCKS)) return $urandom_range(65, 127);
    if (roll < 27 || room == 0) return $urandom_range(room + 1, MAX_BLOCKS);
    if (room > 8 && roll < 80) return $urandom_range(1, 8);
    return $urandom_range(1, room);
  endfunction

  function automatic int pick_block_count();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(65, 127);
    if (roll < 4) return 1;
    if (roll < 6) return MAX_BLOCKS;
    return $urandom_range(1, MAX_BLOCKS);
  endfunction

  initial begin
    int sent;
    int phase_len;
    tracker = new();
    steady = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(0);
    send_request(1);
    send_request(3);
    send_request(65);
    send_request(127);
    send_request(60);
    send_request(1);
    send_request(0);
    set_blocks(1);
    send_request(1);
    send_request(1);
    send_request(0);
    set_blocks(0);
    send_request(1);
    send_request(0);
    send_request(64);
    set_blocks(127);
    send_request(64);
    send_request(0);
    set_blocks(65);
    send_request(2);
    send_request(63);
    send_request(62);

    sent = 0;
    while (sent < 460) begin
      set_blocks(pick_block_count());
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(4, 16);
      repeat (phase_len) begin
        send_request(pick_length());
        sent++;
      end
    end

    start <= 1'b0;
    while (tracker.awaited_words.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
